FILE: design/pdws_pkg.sv
`default_nettype none
// ============================================================================
// pdws_pkg
// Shared types and constants of the pointer delta weighted smoother.
// ============================================================================
package pdws_pkg;

   localparam int DELTA_W   = 16;
   localparam int DECAY_W   = 16;
   localparam int WT_W      = 17;
   localparam int SMOOTH_W  = 24;
   localparam int WHEEL_W   = 18;
   localparam int QUO_W     = 24;
   localparam int DIV_STEPS = 24;

   localparam logic [WT_W-1:0] WEIGHT_ONE = 17'd65536;

   // Multiply by the rounded-up reciprocal of 15 and shift: exact floor(32*n/15)
   // for every 16-bit magnitude n.
   localparam int WHEEL_RECIP_W = 24;
   localparam logic [WHEEL_RECIP_W-1:0] WHEEL_RECIP = WHEEL_RECIP_W'((2**27 + 7) / 15);
   localparam int WHEEL_SHIFT = 22;

   typedef struct packed {
      logic load;
      logic push;
      logic walk;
      logic div_init;
      logic div_step;
      logic commit;
   } pdws_lane_ctl_type;

endpackage
`default_nettype wire

FILE: design/pdws_weight_gen.sv
`default_nettype none
// ============================================================================
// pdws_weight_gen
// Produces the geometric weight sequence and its running total while the
// lanes walk the history, one weight per cycle.
// ============================================================================
module pdws_weight_gen #(
   parameter int HISTORY_DEPTH = 16,
   localparam int LEN_W = $clog2(HISTORY_DEPTH + 1),
   localparam int TOT_W = pdws_pkg::WT_W + LEN_W
) (
   input  wire logic                                clock,
   input  wire pdws_pkg::pdws_lane_ctl_type         ctl,
   input  wire logic [pdws_pkg::DECAY_W-1:0]        decay,
   output logic [pdws_pkg::WT_W-1:0]                wt,
   output logic [TOT_W-1:0]                         total
);
   import pdws_pkg::*;

   logic [WT_W-1:0]         wt_ff, wt_in;
   logic [TOT_W-1:0]        total_ff, total_in;
   logic [WT_W+DECAY_W-1:0] wt_prod;

   assign wt_prod = wt_ff * decay;

   always_comb begin
      wt_in    = wt_ff;
      total_in = total_ff;
      if (ctl.push) begin
         wt_in    = WEIGHT_ONE;
         total_in = '0;
      end else if (ctl.walk) begin
         wt_in    = wt_prod[WT_W+DECAY_W-1:DECAY_W];
         total_in = total_ff + TOT_W'(wt_ff);
      end
   end

   always_ff @(posedge clock) begin
      wt_ff    <= wt_in;
      total_ff <= total_in;
   end

   assign wt    = wt_ff;
   assign total = total_ff;

endmodule
`default_nettype wire

FILE: design/pdws_lane.sv
`default_nettype none
// ============================================================================
// pdws_lane
// One axis: history window, weighted accumulate, restoring divider and
// two-point smoothing against the previous filtered value, or, with filtering off, the latched delta scaled by 256.
// ============================================================================
module pdws_lane #(
   parameter int HISTORY_DEPTH = 16,
   localparam int LEN_W = $clog2(HISTORY_DEPTH + 1),
   localparam int TOT_W = pdws_pkg::WT_W + LEN_W
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire pdws_pkg::pdws_lane_ctl_type         ctl,
   input  wire logic [LEN_W-1:0]                    len,
   input  wire logic                                filter_en,
   input  wire logic signed [pdws_pkg::DELTA_W-1:0] delta,
   input  wire logic [pdws_pkg::WT_W-1:0]           wt,
   input  wire logic [TOT_W-1:0]                    total,
   output logic signed [pdws_pkg::SMOOTH_W-1:0]     result
);
   import pdws_pkg::*;

   localparam int PROD_W = DELTA_W + WT_W + 1;
   localparam int ACC_W  = PROD_W + LEN_W;

   logic signed [DELTA_W-1:0]  hist_ff [HISTORY_DEPTH];
   logic signed [DELTA_W-1:0]  hist_in [HISTORY_DEPTH];
   logic signed [DELTA_W-1:0]  delta_ff, delta_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic [TOT_W-1:0]           rem_ff, rem_in;
   logic [QUO_W-1:0]           nq_ff, nq_in;
   logic                       neg_ff, neg_in;
   logic signed [SMOOTH_W-1:0] prev_ff, prev_in;

   logic signed [PROD_W-1:0]   prod;
   logic [ACC_W-1:0]           mag;
   logic [TOT_W:0]             trial;
   logic                       fits;
   logic signed [SMOOTH_W-1:0] fx;
   logic signed [SMOOTH_W:0]   pair_sum;
   logic signed [SMOOTH_W:0]   pair_adj;

   // The window rotates during the walk so that the entry in use is always
   // at the head; after the len-entry walk it is back in its original order.
   for (genvar j = 0; j < HISTORY_DEPTH; j++) begin : g_hist
      always_comb begin
         hist_in[j] = hist_ff[j];
         if (ctl.push) begin
            if (j == 0) begin
               hist_in[j] = delta_ff;
            end else if (len > LEN_W'(j)) begin
               hist_in[j] = hist_ff[(j == 0) ? 0 : j - 1];
            end
         end else if (ctl.walk) begin
            if (len == LEN_W'(j + 1)) begin
               hist_in[j] = hist_ff[0];
            end else if (len > LEN_W'(j + 1)) begin
               hist_in[j] = hist_ff[(j + 1 < HISTORY_DEPTH) ? j + 1 : j];
            end
         end
      end
   end

   assign prod  = hist_ff[0] * $signed({1'b0, wt});
   assign mag   = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
   assign trial = {rem_ff, nq_ff[QUO_W-1]};
   assign fits  = (trial >= {1'b0, total});

   always_comb begin
      delta_in = delta_ff;
      acc_in   = acc_ff;
      rem_in   = rem_ff;
      nq_in    = nq_ff;
      neg_in   = neg_ff;
      prev_in  = prev_ff;
      if (ctl.load) begin
         delta_in = delta;
      end
      if (ctl.push) begin
         acc_in = '0;
      end else if (ctl.walk) begin
         acc_in = acc_ff + {{LEN_W{prod[PROD_W-1]}}, prod};
      end
      if (ctl.div_init) begin
         neg_in = acc_ff[ACC_W-1];
         rem_in = mag[16 +: TOT_W];
         nq_in  = {mag[15:0], 8'd0};
      end else if (ctl.div_step) begin
         rem_in = fits ? TOT_W'(trial - {1'b0, total}) : trial[TOT_W-1:0];
         nq_in  = {nq_ff[QUO_W-2:0], fits};
      end
      if (ctl.commit) begin
         prev_in = fx;
      end
   end

   assign fx       = neg_ff ? (~nq_ff + QUO_W'(1)) : nq_ff;
   assign pair_sum = {fx[SMOOTH_W-1], fx} + {prev_ff[SMOOTH_W-1], prev_ff};
   assign pair_adj = pair_sum + {{SMOOTH_W{1'b0}}, pair_sum[SMOOTH_W]};
   assign result   = filter_en ? pair_adj[SMOOTH_W:1] : {delta_ff, 8'd0};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < HISTORY_DEPTH; k++) begin
            hist_ff[k] <= '0;
         end
         prev_ff <= '0;
      end else begin
         hist_ff <= hist_in;
         prev_ff <= prev_in;
      end
   end

   always_ff @(posedge clock) begin
      delta_ff <= delta_in;
      acc_ff   <= acc_in;
      rem_ff   <= rem_in;
      nq_ff    <= nq_in;
      neg_ff   <= neg_in;
   end

endmodule
`default_nettype wire

FILE: design/pdws_wheel.sv
`default_nettype none
// ============================================================================
// pdws_wheel
// Converts a raw wheel count into detents in Q9.8, truncated toward zero.
// ============================================================================
module pdws_wheel (
   input  wire logic                                clock,
   input  wire logic                                load,
   input  wire logic                                wheel_present,
   input  wire logic signed [pdws_pkg::DELTA_W-1:0] wheel_count,
   output logic signed [pdws_pkg::WHEEL_W-1:0]      steps
);
   import pdws_pkg::*;

   localparam int PROD_W = DELTA_W + WHEEL_RECIP_W;

   logic               present_ff, present_in;
   logic               neg_ff, neg_in;
   logic [DELTA_W-1:0] mag_ff, mag_in;
   logic [PROD_W-1:0]  prod;
   logic [WHEEL_W-1:0] quo;

   always_comb begin
      present_in = present_ff;
      neg_in     = neg_ff;
      mag_in     = mag_ff;
      if (load) begin
         present_in = wheel_present;
         neg_in     = wheel_count[DELTA_W-1];
         mag_in     = wheel_count[DELTA_W-1] ? DELTA_W'(-wheel_count)
                                             : DELTA_W'(wheel_count);
      end
   end

   always_ff @(posedge clock) begin
      present_ff <= present_in;
      neg_ff     <= neg_in;
      mag_ff     <= mag_in;
   end

   assign prod  = mag_ff * WHEEL_RECIP;
   assign quo   = prod[WHEEL_SHIFT +: WHEEL_W];
   assign steps = !present_ff ? '0 : (neg_ff ? (~quo + WHEEL_W'(1)) : quo);

endmodule
`default_nettype wire

FILE: design/pointer_delta_weighted_smoother_top.sv
`default_nettype none
// ============================================================================
// pointer_delta_weighted_smoother_top
// Weighted-history smoothing of relative pointer reports, plus wheel scaling.
// ============================================================================
// Usage:
//   A report beat enters on req_* (valid/ready) and produces one result beat
//   on rsp_* (valid/ready). Settings are written through the csr_* port:
//   decay_weight at 0x0, history_length at 0x4, filter_enable at 0x8.
//   With filtering on, an accepted report goes through a push step, the
//   shared weight/accumulate walk over len history entries (one history
//   entry per cycle), where len is history_length clamped to
//   1..HISTORY_DEPTH, a divider setup step, the bit-serial divider and the
//   finish step. With filtering off it goes straight to the finish step.
//   The finish step loads the output register and returns to idle, so the
//   next report can be accepted in the same cycle as the result is valid.
//   A finished result sits in the output register; while the receiver
//   stalls, a new report is still taken and processed, and its result waits
//   in the finish step until the register is free.
//   Reset clears the history, the previous filtered values and the settings
//   to their defaults; the block is ready on the first cycle after reset.
// ============================================================================
module pointer_delta_weighted_smoother_top #(
   parameter int HISTORY_DEPTH = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic signed [pdws_pkg::DELTA_W-1:0] req_delta_x,
   input  wire logic signed [pdws_pkg::DELTA_W-1:0] req_delta_y,
   input  wire logic                                req_wheel_present,
   input  wire logic signed [pdws_pkg::DELTA_W-1:0] req_wheel_count,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic signed [pdws_pkg::SMOOTH_W-1:0]     rsp_smooth_x,
   output logic signed [pdws_pkg::SMOOTH_W-1:0]     rsp_smooth_y,
   output logic signed [pdws_pkg::WHEEL_W-1:0]      rsp_wheel_steps,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [3:0]                          csr_paddr,
   input  wire logic [31:0]                         csr_pwdata,
   output logic [31:0]                              csr_prdata,
   output logic                                     csr_pready
);
   import pdws_pkg::*;

   localparam int LEN_W = $clog2(HISTORY_DEPTH + 1);
   localparam int TOT_W = WT_W + LEN_W;
   localparam int CNT_W = (LEN_W > 5) ? LEN_W : 5;
   localparam int HL_W  = 5;

   localparam logic [1:0] REG_DECAY  = 2'd0;
   localparam logic [1:0] REG_LENGTH = 2'd1;
   localparam logic [1:0] REG_ENABLE = 2'd2;

   localparam logic [DECAY_W-1:0] DECAY_RESET  = 16'd13107;
   localparam logic [HL_W-1:0]    LENGTH_RESET = 5'd10;

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_PUSH     = 3'd1;
   localparam logic [2:0] ST_WALK     = 3'd2;
   localparam logic [2:0] ST_DIV_INIT = 3'd3;
   localparam logic [2:0] ST_DIV      = 3'd4;
   localparam logic [2:0] ST_FINISH   = 3'd5;

   logic [DECAY_W-1:0] decay_ff, decay_in;
   logic [HL_W-1:0]    hlen_ff, hlen_in;
   logic               enable_ff, enable_in;

   logic [2:0]         state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic               filt_ff, filt_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SMOOTH_W-1:0] rsp_x_ff, rsp_x_in;
   logic signed [SMOOTH_W-1:0] rsp_y_ff, rsp_y_in;
   logic signed [WHEEL_W-1:0]  rsp_w_ff, rsp_w_in;

   logic                       csr_write;
   logic                       req_take;
   logic                       out_free;
   logic                       finish_go;
   logic [LEN_W-1:0]           len_clamped;
   logic [CNT_W-1:0]           walk_last;
   pdws_lane_ctl_type          ctl;
   logic [WT_W-1:0]            wt;
   logic [TOT_W-1:0]           total;
   logic signed [SMOOTH_W-1:0] lane_x;
   logic signed [SMOOTH_W-1:0] lane_y;
   logic signed [WHEEL_W-1:0]  wheel_steps;

   // Configuration registers.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      decay_in  = decay_ff;
      hlen_in   = hlen_ff;
      enable_in = enable_ff;
      if (csr_write) begin
         case (csr_paddr[3:2])
            REG_DECAY:  decay_in  = csr_pwdata[DECAY_W-1:0];
            REG_LENGTH: hlen_in   = csr_pwdata[HL_W-1:0];
            REG_ENABLE: enable_in = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_DECAY:  csr_prdata = {16'd0, decay_ff};
         REG_LENGTH: csr_prdata = {27'd0, hlen_ff};
         REG_ENABLE: csr_prdata = {31'd0, enable_ff};
         default:    csr_prdata = '0;
      endcase
   end

   always_comb begin
      if (hlen_ff == '0) begin
         len_clamped = LEN_W'(1);
      end else if (int'(hlen_ff) > HISTORY_DEPTH) begin
         len_clamped = LEN_W'(HISTORY_DEPTH);
      end else begin
         len_clamped = LEN_W'(hlen_ff);
      end
   end

   // Sequencer.
   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign finish_go = (state_ff == ST_FINISH) && out_free;
   assign walk_last = CNT_W'(len_ff) - CNT_W'(1);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      len_in   = len_ff;
      filt_in  = filt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               len_in   = len_clamped;
               filt_in  = enable_ff;
               state_in = enable_ff ? ST_PUSH : ST_FINISH;
            end
         end
         ST_PUSH: begin
            cnt_in   = '0;
            state_in = ST_WALK;
         end
         ST_WALK: begin
            if (cnt_ff == walk_last) begin
               cnt_in   = '0;
               state_in = ST_DIV_INIT;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_DIV_INIT: begin
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_FINISH;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctl.load     = req_take;
      ctl.push     = (state_ff == ST_PUSH);
      ctl.walk     = (state_ff == ST_WALK);
      ctl.div_init = (state_ff == ST_DIV_INIT);
      ctl.div_step = (state_ff == ST_DIV);
      ctl.commit   = finish_go && filt_ff;
   end

   pdws_weight_gen #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_weight (
      .clock (clock),
      .ctl   (ctl),
      .decay (decay_ff),
      .wt    (wt),
      .total (total)
   );

   pdws_lane #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_lane_x (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .len       (len_ff),
      .filter_en (filt_ff),
      .delta     (req_delta_x),
      .wt        (wt),
      .total     (total),
      .result    (lane_x)
   );

   pdws_lane #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_lane_y (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .len       (len_ff),
      .filter_en (filt_ff),
      .delta     (req_delta_y),
      .wt        (wt),
      .total     (total),
      .result    (lane_y)
   );

   pdws_wheel u_wheel (
      .clock         (clock),
      .load          (req_take),
      .wheel_present (req_wheel_present),
      .wheel_count   (req_wheel_count),
      .steps         (wheel_steps)
   );

   // Output register: merges both lanes and the wheel into one result beat.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_w_in     = rsp_w_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (finish_go) begin
         rsp_valid_in = 1'b1;
         rsp_x_in     = lane_x;
         rsp_y_in     = lane_y;
         rsp_w_in     = wheel_steps;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         decay_ff     <= DECAY_RESET;
         hlen_ff      <= LENGTH_RESET;
         enable_ff    <= 1'b1;
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         decay_ff     <= decay_in;
         hlen_ff      <= hlen_in;
         enable_ff    <= enable_in;
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff   <= len_in;
      filt_ff  <= filt_in;
      rsp_x_ff <= rsp_x_in;
      rsp_y_ff <= rsp_y_in;
      rsp_w_ff <= rsp_w_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_smooth_x    = rsp_x_ff;
   assign rsp_smooth_y    = rsp_y_ff;
   assign rsp_wheel_steps = rsp_w_ff;

   a_take_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff != ST_IDLE))
      else $error("Sequencer stayed idle after taking a beat.");

   a_div_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) && (cnt_ff == CNT_W'(DIV_STEPS - 1)) |=> (state_ff == ST_FINISH))
      else $error("Divider did not hand over to the finish step.");

   a_finish_loads: assert property (@(posedge clock) disable iff (reset)
      finish_go |=> rsp_valid_ff && (state_ff == ST_IDLE))
      else $error("Finished result was not loaded into the output register.");

   a_walk_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> (cnt_ff < CNT_W'(len_ff)))
      else $error("History walk ran past the window length.");

endmodule
`default_nettype wire

FILE: dv/tb.sv
`timescale 1ns / 100ps
// ============================================================================
// tb
// Self-checking bench for the pointer delta weighted smoother. Report beats
// are driven with bursty valid timing while the result side stalls on its own
// pattern. A built-in model of the weighted history, the two-sample smoothing
// and the wheel scaling predicts every result beat, which is compared field by
// field. Settings are changed over the CSR port only while the block is idle.
// ============================================================================
module tb;

   localparam int HISTORY_DEPTH  = 16;
   localparam int HALF_PERIOD    = 5;
   localparam int RESET_CYCLES   = 7;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int MAX_REPORTED   = 10;
   localparam int RANDOM_REPORTS = 525;
   localparam int SETTLE_CYCLES  = HISTORY_DEPTH + 32;

   typedef enum logic [1:0] {
      REG_DECAY_WEIGHT   = 2'd0,
      REG_HISTORY_LENGTH = 2'd1,
      REG_FILTER_ENABLE  = 2'd2,
      REG_UNMAPPED       = 2'd3
   } csr_index_type;

   typedef struct {
      logic signed [pdws_pkg::SMOOTH_W-1:0] x;
      logic signed [pdws_pkg::SMOOTH_W-1:0] y;
      logic signed [pdws_pkg::WHEEL_W-1:0]  wheel;
   } smoothed_beat_type;

   logic                                 clock;
   logic                                 reset;
   logic                                 req_valid;
   logic                                 req_ready;
   logic signed [pdws_pkg::DELTA_W-1:0]  req_delta_x;
   logic signed [pdws_pkg::DELTA_W-1:0]  req_delta_y;
   logic                                 req_wheel_present;
   logic signed [pdws_pkg::DELTA_W-1:0]  req_wheel_count;
   logic                                 rsp_valid;
   logic                                 rsp_ready;
   logic signed [pdws_pkg::SMOOTH_W-1:0] rsp_smooth_x;
   logic signed [pdws_pkg::SMOOTH_W-1:0] rsp_smooth_y;
   logic signed [pdws_pkg::WHEEL_W-1:0]  rsp_wheel_steps;
   logic                                 csr_psel;
   logic                                 csr_penable;
   logic                                 csr_pwrite;
   logic [3:0]                           csr_paddr;
   logic [31:0]                          csr_pwdata;
   logic [31:0]                          csr_prdata;
   logic                                 csr_pready;

   logic [15:0]                          decay_ratio;
   logic [4:0]                           window_len;
   logic                                 filter_on;
   logic signed [pdws_pkg::DELTA_W-1:0]  past_x [HISTORY_DEPTH];
   logic signed [pdws_pkg::DELTA_W-1:0]  past_y [HISTORY_DEPTH];
   longint                               prev_filtered_x;
   longint                               prev_filtered_y;

   smoothed_beat_type                    pending_results [$];
   int                                   mismatch_count;
   int                                   idle_cycles;
   int                                   burst_left;

   pointer_delta_weighted_smoother_top #(
      .HISTORY_DEPTH(HISTORY_DEPTH)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_delta_x(req_delta_x),
      .req_delta_y(req_delta_y),
      .req_wheel_present(req_wheel_present),
      .req_wheel_count(req_wheel_count),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_smooth_x(rsp_smooth_x),
      .rsp_smooth_y(rsp_smooth_y),
      .rsp_wheel_steps(rsp_wheel_steps),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #(HALF_PERIOD) clock = ~clock;
   end

   function automatic void apply_setting(csr_index_type idx, logic [31:0] value);
      case (idx)
         REG_DECAY_WEIGHT:   decay_ratio = value[15:0];
         REG_HISTORY_LENGTH: window_len  = value[4:0];
         REG_FILTER_ENABLE:  filter_on   = value[0];
         default: ;
      endcase
   endfunction

   function automatic logic [31:0] setting_value(csr_index_type idx);
      case (idx)
         REG_DECAY_WEIGHT:   return {16'd0, decay_ratio};
         REG_HISTORY_LENGTH: return {27'd0, window_len};
         REG_FILTER_ENABLE:  return {31'd0, filter_on};
         default:            return 32'd0;
      endcase
   endfunction

   function automatic smoothed_beat_type smooth_report(
      input logic signed [pdws_pkg::DELTA_W-1:0] dx,
      input logic signed [pdws_pkg::DELTA_W-1:0] dy,
      input logic                                wheel_on,
      input logic signed [pdws_pkg::DELTA_W-1:0] wheel_raw
   );
      int                len;
      longint            wt;
      longint            acc_x;
      longint            acc_y;
      longint            total;
      longint            fx;
      longint            fy;
      longint            sx;
      longint            sy;
      longint            steps;
      smoothed_beat_type beat;
      if (filter_on) begin
         len = int'(window_len);
         if (len < 1) len = 1;
         if (len > HISTORY_DEPTH) len = HISTORY_DEPTH;
         // Only the active window shifts; deeper entries keep stale values.
         for (int i = len - 1; i > 0; i--) begin
            past_x[i] = past_x[i-1];
            past_y[i] = past_y[i-1];
         end
         past_x[0] = dx;
         past_y[0] = dy;
         wt    = 65536;
         acc_x = 0;
         acc_y = 0;
         total = 0;
         for (int i = 0; i < len; i++) begin
            acc_x += longint'(past_x[i]) * wt;
            acc_y += longint'(past_y[i]) * wt;
            total += wt;
            wt = (wt * longint'(decay_ratio)) >> 16;
         end
         fx = (acc_x * 256) / total;
         fy = (acc_y * 256) / total;
         sx = (fx + prev_filtered_x) / 2;
         sy = (fy + prev_filtered_y) / 2;
         prev_filtered_x = fx;
         prev_filtered_y = fy;
      end else begin
         sx = longint'(dx) * 256;
         sy = longint'(dy) * 256;
      end
      steps = wheel_on ? (longint'(wheel_raw) * 256) / 120 : 0;
      beat.x     = sx[pdws_pkg::SMOOTH_W-1:0];
      beat.y     = sy[pdws_pkg::SMOOTH_W-1:0];
      beat.wheel = steps[pdws_pkg::WHEEL_W-1:0];
      return beat;
   endfunction

   task automatic note_mismatch(input string what, input longint want_v, input longint got_v);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTED)
         $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want_v, got_v);
   endtask

   always @(posedge clock) begin : scoreboard
      smoothed_beat_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               note_mismatch("unexpected result beat", 0, rsp_smooth_x);
            end else begin
               want = pending_results.pop_front();
               if (rsp_smooth_x !== want.x) note_mismatch("smooth_x", want.x, rsp_smooth_x);
               if (rsp_smooth_y !== want.y) note_mismatch("smooth_y", want.y, rsp_smooth_y);
               if (rsp_wheel_steps !== want.wheel)
                  note_mismatch("wheel_steps", want.wheel, rsp_wheel_steps);
            end
         end
         if (req_valid && req_ready)
            pending_results.push_back(smooth_report(req_delta_x, req_delta_y,
                                                    req_wheel_present, req_wheel_count));
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_psel && csr_penable && csr_pready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : receiver
      int   run_left;
      logic ready_next;
      rsp_ready = 1'b0;
      run_left  = 0;
      forever begin
         @(negedge clock);
         if (run_left == 0) begin
            ready_next = ($urandom_range(0, 2) != 0);
            run_left   = ready_next ? $urandom_range(1, 48) : $urandom_range(1, 24);
            rsp_ready <= ready_next;
         end else begin
            run_left--;
         end
      end
   end

   task automatic send_report(
      input logic signed [pdws_pkg::DELTA_W-1:0] dx,
      input logic signed [pdws_pkg::DELTA_W-1:0] dy,
      input logic                                wheel_on,
      input logic signed [pdws_pkg::DELTA_W-1:0] wheel_raw
   );
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
         if (gap > 0) begin
            @(negedge clock);
            req_valid         <= 1'b0;
            req_delta_x       <= 16'($urandom);
            req_delta_y       <= 16'($urandom);
            req_wheel_present <= 1'($urandom);
            req_wheel_count   <= 16'($urandom);
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid         <= 1'b1;
      req_delta_x       <= dx;
      req_delta_y       <= dy;
      req_wheel_present <= wheel_on;
      req_wheel_count   <= wheel_raw;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(input logic write, input csr_index_type idx,
                             input logic [31:0] data, output logic [31:0] rdata);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic write_setting(input csr_index_type idx, input logic [31:0] value);
      logic [31:0] unused;
      csr_access(1'b1, idx, value, unused);
      apply_setting(idx, value);
   endtask

   task automatic check_setting(input csr_index_type idx);
      logic [31:0] got;
      csr_access(1'b0, idx, $urandom, got);
      if (got !== setting_value(idx)) note_mismatch(idx.name(), setting_value(idx), got);
   endtask

   function automatic logic signed [15:0] random_delta();
      int v;
      v = int'($urandom_range(0, 256)) - 128;
      case ($urandom_range(0, 7))
         0:       return 16'sh8000;
         1:       return 16'sh7FFF;
         2, 3, 4: return 16'(v);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic signed [15:0] random_wheel();
      int v;
      v = (int'($urandom_range(0, 10)) - 5) * 120;
      case ($urandom_range(0, 5))
         0:       return 16'(v);
         1:       return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic test_default_extremes();
      check_setting(REG_DECAY_WEIGHT);
      check_setting(REG_HISTORY_LENGTH);
      check_setting(REG_FILTER_ENABLE);
      send_report(16'sh7FFF, 16'sh8000, 1'b1, 16'sh7FFF);
      send_report(16'sh8000, 16'sh7FFF, 1'b1, 16'sh8000);
      send_report(16'sd0, 16'sd0, 1'b0, -16'sd1234);
      send_report(-16'sd1, 16'sd1, 1'b1, 16'sd120);
      send_report(16'sd1, -16'sd1, 1'b1, -16'sd120);
      send_report(16'sh7FFF, 16'sh7FFF, 1'b1, 16'sd1);
      send_report(16'sh8000, 16'sh8000, 1'b1, -16'sd1);
      send_report(16'sd0, 16'sd0, 1'b1, 16'sd0);
      wait_idle();
   endtask

   task automatic test_filter_bypass();
      write_setting(REG_FILTER_ENABLE, 32'hFFFF_FFF0);
      check_setting(REG_FILTER_ENABLE);
      send_report(16'sh7FFF, 16'sh8000, 1'b1, 16'sh8000);
      send_report(16'sh8000, 16'sh7FFF, 1'b0, 16'sh7FFF);
      send_report(16'sd0, -16'sd1, 1'b1, -16'sd120);
      wait_idle();
      write_setting(REG_FILTER_ENABLE, 32'd1);
   endtask

   task automatic test_length_clamp();
      write_setting(REG_HISTORY_LENGTH, 32'd0);
      check_setting(REG_HISTORY_LENGTH);
      send_report(16'sd100, -16'sd100, 1'b1, 16'sd240);
      send_report(-16'sd5, 16'sd7, 1'b0, 16'sd0);
      wait_idle();
      write_setting(REG_HISTORY_LENGTH, 32'd31);
      check_setting(REG_HISTORY_LENGTH);
      send_report(16'sh7FFF, 16'sh8000, 1'b1, 16'sd359);
      send_report(16'sd3, -16'sd3, 1'b1, -16'sd359);
      wait_idle();
      write_setting(REG_HISTORY_LENGTH, 32'd17);
      send_report(-16'sd300, 16'sd300, 1'b0, 16'sd5);
      wait_idle();
   endtask

   task automatic test_stale_entries();
      write_setting(REG_HISTORY_LENGTH, 32'd16);
      send_report(16'sd1000, -16'sd1000, 1'b0, 16'sd0);
      send_report(16'sd2000, -16'sd2000, 1'b0, 16'sd0);
      wait_idle();
      write_setting(REG_HISTORY_LENGTH, 32'd2);
      send_report(-16'sd50, 16'sd50, 1'b0, 16'sd0);
      send_report(-16'sd60, 16'sd60, 1'b0, 16'sd0);
      wait_idle();
      write_setting(REG_HISTORY_LENGTH, 32'd16);
      send_report(16'sd7, 16'sd9, 1'b1, 16'sd600);
      send_report(16'sd8, 16'sd10, 1'b1, -16'sd600);
      wait_idle();
   endtask

   task automatic test_decay_extremes();
      write_setting(REG_DECAY_WEIGHT, 32'hABCD_0000);
      check_setting(REG_DECAY_WEIGHT);
      send_report(16'sd500, -16'sd500, 1'b1, 16'sd119);
      wait_idle();
      write_setting(REG_DECAY_WEIGHT, 32'h0000_FFFF);
      check_setting(REG_DECAY_WEIGHT);
      send_report(-16'sd500, 16'sd500, 1'b1, -16'sd119);
      wait_idle();
      write_setting(REG_DECAY_WEIGHT, 32'd13107);
   endtask

   task automatic test_unmapped_register();
      write_setting(REG_UNMAPPED, 32'hFFFF_FFFF);
      check_setting(REG_DECAY_WEIGHT);
      check_setting(REG_HISTORY_LENGTH);
      check_setting(REG_FILTER_ENABLE);
      send_report(16'sd12, -16'sd34, 1'b1, 16'sd1200);
      wait_idle();
   endtask

   task automatic test_random_traffic(input int total);
      int          sent;
      int          phase_len;
      logic [15:0] decay_pick;
      logic [4:0]  len_pick;
      sent = 0;
      while (sent < total) begin
         case ($urandom_range(0, 5))
            0:       decay_pick = 16'd0;
            1:       decay_pick = 16'hFFFF;
            2:       decay_pick = 16'd13107;
            default: decay_pick = 16'($urandom);
         endcase
         case ($urandom_range(0, 7))
            0:       len_pick = 5'd0;
            1:       len_pick = 5'd1;
            2:       len_pick = 5'd16;
            3:       len_pick = 5'($urandom_range(17, 31));
            default: len_pick = 5'($urandom_range(2, 15));
         endcase
         write_setting(REG_DECAY_WEIGHT, {16'($urandom), decay_pick});
         write_setting(REG_HISTORY_LENGTH, {27'($urandom), len_pick});
         write_setting(REG_FILTER_ENABLE, {31'($urandom), 1'($urandom_range(0, 4) != 0)});
         if ($urandom_range(0, 3) == 0) begin
            write_setting(REG_UNMAPPED, $urandom);
            check_setting(REG_DECAY_WEIGHT);
            check_setting(REG_HISTORY_LENGTH);
            check_setting(REG_FILTER_ENABLE);
         end
         phase_len = $urandom_range(15, 50);
         for (int k = 0; k < phase_len && sent < total; k++) begin
            send_report(random_delta(), random_delta(), 1'($urandom), random_wheel());
            sent++;
         end
         wait_idle();
      end
   endtask

   initial begin
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_delta_x       = '0;
      req_delta_y       = '0;
      req_wheel_present = 1'b0;
      req_wheel_count   = '0;
      csr_psel          = 1'b0;
      csr_penable       = 1'b0;
      csr_pwrite        = 1'b0;
      csr_paddr         = '0;
      csr_pwdata        = '0;
      decay_ratio       = 16'd13107;
      window_len        = 5'd10;
      filter_on         = 1'b1;
      prev_filtered_x   = 0;
      prev_filtered_y   = 0;
      mismatch_count    = 0;
      idle_cycles       = 0;
      burst_left        = 0;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
         past_x[i] = '0;
         past_y[i] = '0;
      end
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_default_extremes();
      test_filter_bypass();
      test_length_clamp();
      test_stale_entries();
      test_decay_extremes();
      test_unmapped_register();
      test_random_traffic(RANDOM_REPORTS);

      if (pending_results.size() != 0) mismatch_count++;
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

FILE: filelist.f
design/pdws_pkg.sv
design/pdws_weight_gen.sv
design/pdws_lane.sv
design/pdws_wheel.sv
design/pointer_delta_weighted_smoother_top.sv
dv/tb.sv
